FILE: rtl/rhpm_pkg.sv
// Shared types and constants for the rolling hash pattern matcher.
// Used by rhpm_ctrl, rhpm_dp and rolling_hash_pattern_matcher; depends on nothing.
package rhpm_pkg;

	localparam int unsigned MAX_PATTERN_DEF  = 32;
	localparam int unsigned HASH_MODULUS_DEF = 101;
	localparam int unsigned POS_W            = 32;
	localparam int unsigned BYTE_W           = 8;
	localparam int unsigned CMD_W            = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PATTERN = 2'd0,
		CMD_TEXT    = 2'd1,
		CMD_CLEAR   = 2'd2
	} rhpm_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_POW,
		S_PD_LOAD,
		S_PD,
		S_GONE_LOAD,
		S_GONE,
		S_SUB,
		S_WD_LOAD,
		S_WD,
		S_TXT_END,
		S_CMP_RD,
		S_CMP_CHK,
		S_EMIT
	} rhpm_state_t;

	// Operations of the shared bit-serial modular multiply unit.
	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_STEP,
		MOP_LOAD_POW,
		MOP_LOAD_PD,
		MOP_LOAD_GONE,
		MOP_LOAD_WD
	} rhpm_mop_t;

	typedef struct packed {
		logic      latch;
		logic      clear_all;
		logic      restart;
		logic      pat_write;
		logic      power_one;
		rhpm_mop_t mop;
		logic      power_take;
		logic      pd_take;
		logic      wd_sub;
		logic      wd_take;
		logic      gone_read;
		logic      txt_write;
		logic      cmp_start;
		logic      cmp_read;
		logic      emit;
	} rhpm_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             count_zero;
		logic             count_full;
		logic             pos_ge_len;
		logic             digest_eq;
		logic             mul_last;
		logic             cmp_eq;
		logic             cmp_last;
		logic             out_free;
	} rhpm_sts_t;

endpackage

FILE: rtl/rhpm_ctrl.sv
// Controller state machine of the rolling hash pattern matcher.
// Sequences the datapath through commands; depends on rhpm_pkg.
module rhpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rhpm_pkg::rhpm_sts_t sts,
	output rhpm_pkg::rhpm_ctl_t ctl
);
	import rhpm_pkg::*;

	rhpm_state_t state_q;
	rhpm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (sts.cmd)
					CMD_PATTERN: begin
						if (sts.count_full) state_d = S_IDLE;
						else if (sts.count_zero) state_d = S_PD_LOAD;
						else state_d = S_POW;
					end
					CMD_TEXT: begin
						if (sts.count_zero) state_d = S_IDLE;
						else if (sts.pos_ge_len) state_d = S_GONE_LOAD;
						else state_d = S_WD_LOAD;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_POW: begin
				if (sts.mul_last) state_d = S_PD_LOAD;
			end
			S_PD_LOAD: state_d = S_PD;
			S_PD: begin
				if (sts.mul_last) state_d = S_IDLE;
			end
			S_GONE_LOAD: state_d = S_GONE;
			S_GONE: begin
				if (sts.mul_last) state_d = S_SUB;
			end
			S_SUB: state_d = S_WD_LOAD;
			S_WD_LOAD: state_d = S_WD;
			S_WD: begin
				if (sts.mul_last) state_d = S_TXT_END;
			end
			S_TXT_END: begin
				if (sts.pos_ge_len && sts.digest_eq) state_d = S_CMP_RD;
				else state_d = S_IDLE;
			end
			S_CMP_RD: state_d = S_CMP_CHK;
			S_CMP_CHK: begin
				if (!sts.cmp_eq) state_d = S_IDLE;
				else if (sts.cmp_last) state_d = S_EMIT;
				else state_d = S_CMP_RD;
			end
			S_EMIT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		ctl.mop  = MOP_NONE;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				ctl.latch = in_valid;
			end
			S_DECODE: begin
				unique case (sts.cmd)
					CMD_PATTERN: begin
						// Every pattern beat restarts the text, even a dropped one.
						ctl.restart = 1'b1;
						if (!sts.count_full) begin
							ctl.pat_write = 1'b1;
							if (sts.count_zero) ctl.power_one = 1'b1;
							else ctl.mop = MOP_LOAD_POW;
						end
					end
					CMD_TEXT: begin
						if (sts.count_zero) ctl.txt_write = 1'b1;
						else if (sts.pos_ge_len) ctl.gone_read = 1'b1;
					end
					CMD_CLEAR: ctl.clear_all = 1'b1;
					default: ;
				endcase
			end
			S_POW: begin
				ctl.mop        = MOP_STEP;
				ctl.power_take = sts.mul_last;
			end
			S_PD_LOAD: ctl.mop = MOP_LOAD_PD;
			S_PD: begin
				ctl.mop     = MOP_STEP;
				ctl.pd_take = sts.mul_last;
			end
			S_GONE_LOAD: ctl.mop = MOP_LOAD_GONE;
			S_GONE: ctl.mop = MOP_STEP;
			S_SUB: ctl.wd_sub = 1'b1;
			S_WD_LOAD: ctl.mop = MOP_LOAD_WD;
			S_WD: begin
				ctl.mop       = MOP_STEP;
				ctl.wd_take   = sts.mul_last;
				ctl.txt_write = sts.mul_last;
			end
			S_TXT_END: begin
				ctl.cmp_start = sts.pos_ge_len && sts.digest_eq;
			end
			S_CMP_RD: ctl.cmp_read = 1'b1;
			S_CMP_CHK: ;
			S_EMIT: ctl.emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/rhpm_dp.sv
// Datapath of the rolling hash pattern matcher: digests, bit-serial modular
// multiply unit, pattern and text memories, byte comparator and result register.
// Depends on rhpm_pkg.
module rhpm_dp #(
	parameter int unsigned MAX_PATTERN  = rhpm_pkg::MAX_PATTERN_DEF,
	parameter int unsigned HASH_MODULUS = rhpm_pkg::HASH_MODULUS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rhpm_pkg::CMD_W-1:0]    command,
	input  logic [rhpm_pkg::BYTE_W-1:0]   data_byte,
	input  rhpm_pkg::rhpm_ctl_t           ctl,
	output rhpm_pkg::rhpm_sts_t           sts,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [rhpm_pkg::POS_W-1:0]    match_start
);
	import rhpm_pkg::*;

	localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
	localparam int unsigned PW = CW + 1;
	localparam int unsigned DW = $clog2(HASH_MODULUS);
	localparam int unsigned SW = $clog2(BYTE_W);
	localparam logic [DW:0]   MOD    = (DW + 1)'(HASH_MODULUS);
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_PATTERN);
	localparam logic [PW-1:0] MAX_P  = PW'(MAX_PATTERN);
	localparam logic [AW-1:0] LAST_A = AW'(MAX_PATTERN - 1);
	localparam logic [SW-1:0] LAST_S = SW'(BYTE_W - 1);

	logic [CMD_W-1:0]  cmd_q;
	logic [BYTE_W-1:0] byte_q;
	logic [CW-1:0]     count_q;
	logic [DW-1:0]     pd_q;
	logic [DW-1:0]     wd_q;
	logic [DW-1:0]     pow_q;
	logic [POS_W-1:0]  pos_q;
	logic [AW-1:0]     wp_q;
	logic [DW-1:0]     acc_q;
	logic [DW-1:0]     addend_q;
	logic [BYTE_W-1:0] bits_q;
	logic [SW-1:0]     step_q;
	logic [CW-1:0]     cmp_j_q;
	logic [AW-1:0]     cmp_a_q;
	logic [BYTE_W-1:0] pat_rd_q;
	logic [BYTE_W-1:0] txt_rd_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  match_q;

	logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
	logic [BYTE_W-1:0] txt_mem [MAX_PATTERN];

	logic [DW:0]   dbl;
	logic [DW:0]   dbl_r;
	logic [DW:0]   sum;
	logic [DW:0]   sum_r;
	logic [DW:0]   diff;
	logic [DW:0]   diff_r;
	logic [AW-1:0] win_start;
	logic [AW-1:0] txt_rd_a;
	logic [PW-1:0] win_t;
	logic [PW-1:0] win_r;

	// One step of the multiply unit: acc = (2 * acc + bit * addend) mod M.
	// Both partial results stay below twice the modulus, so one subtract each.
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= MOD) ? dbl - MOD : dbl;
		sum   = dbl_r + (bits_q[BYTE_W-1] ? {1'b0, addend_q} : '0);
		sum_r = (sum >= MOD) ? sum - MOD : sum;
		diff   = {1'b0, wd_q} + MOD - {1'b0, acc_q};
		diff_r = (diff >= MOD) ? diff - MOD : diff;
	end

	// Oldest byte of the window sits pattern_count slots behind the write pointer.
	always_comb begin
		win_t     = PW'(wp_q) + MAX_P - PW'(count_q);
		win_r     = (win_t >= MAX_P) ? win_t - MAX_P : win_t;
		win_start = win_r[AW-1:0];
		txt_rd_a  = ctl.gone_read ? win_start : cmp_a_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= command;
			byte_q <= data_byte;
		end
		if (ctl.emit) begin
			match_q <= pos_q - POS_W'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pat_write) pat_mem[count_q[AW-1:0]] <= byte_q;
		if (ctl.cmp_read) pat_rd_q <= pat_mem[cmp_j_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.txt_write) txt_mem[wp_q] <= byte_q;
		if (ctl.gone_read || ctl.cmp_read) txt_rd_q <= txt_mem[txt_rd_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pd_q        <= '0;
			wd_q        <= '0;
			pow_q       <= DW'(1);
			pos_q       <= '0;
			wp_q        <= '0;
			acc_q       <= '0;
			addend_q    <= '0;
			bits_q      <= '0;
			step_q      <= '0;
			cmp_j_q     <= '0;
			cmp_a_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (ctl.clear_all) count_q <= '0;
			else if (ctl.pat_write) count_q <= count_q + CW'(1);
			else count_q <= count_q;

			priority if (ctl.clear_all) pd_q <= '0;
			else if (ctl.pd_take) pd_q <= sum_r[DW-1:0];
			else pd_q <= pd_q;

			priority if (ctl.clear_all || ctl.power_one) pow_q <= DW'(1);
			else if (ctl.power_take) pow_q <= sum_r[DW-1:0];
			else pow_q <= pow_q;

			priority if (ctl.clear_all || ctl.restart) wd_q <= '0;
			else if (ctl.wd_sub) wd_q <= diff_r[DW-1:0];
			else if (ctl.wd_take) wd_q <= sum_r[DW-1:0];
			else wd_q <= wd_q;

			priority if (ctl.clear_all || ctl.restart) pos_q <= '0;
			else if (ctl.txt_write && (pos_q != '1)) pos_q <= pos_q + POS_W'(1);
			else pos_q <= pos_q;

			if (ctl.txt_write) begin
				wp_q <= (wp_q == LAST_A) ? '0 : wp_q + AW'(1);
			end

			unique case (ctl.mop)
				MOP_LOAD_POW: begin
					acc_q    <= pow_q;
					addend_q <= '0;
					bits_q   <= '0;
					step_q   <= '0;
				end
				MOP_LOAD_PD: begin
					acc_q    <= pd_q;
					addend_q <= DW'(1);
					bits_q   <= byte_q;
					step_q   <= '0;
				end
				MOP_LOAD_GONE: begin
					acc_q    <= '0;
					addend_q <= pow_q;
					bits_q   <= txt_rd_q;
					step_q   <= '0;
				end
				MOP_LOAD_WD: begin
					acc_q    <= wd_q;
					addend_q <= DW'(1);
					bits_q   <= byte_q;
					step_q   <= '0;
				end
				MOP_STEP: begin
					acc_q  <= sum_r[DW-1:0];
					bits_q <= {bits_q[BYTE_W-2:0], 1'b0};
					step_q <= step_q + SW'(1);
				end
				default: ;
			endcase

			priority if (ctl.cmp_start) begin
				cmp_j_q <= '0;
				cmp_a_q <= win_start;
			end else if (ctl.cmp_read) begin
				cmp_j_q <= cmp_j_q + CW'(1);
				cmp_a_q <= (cmp_a_q == LAST_A) ? '0 : cmp_a_q + AW'(1);
			end else begin
				cmp_j_q <= cmp_j_q;
				cmp_a_q <= cmp_a_q;
			end

			priority if (ctl.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			else out_valid_q <= out_valid_q;
		end
	end

	always_comb begin
		sts.cmd        = cmd_q;
		sts.count_zero = (count_q == '0);
		sts.count_full = (count_q == MAX_C);
		sts.pos_ge_len = (pos_q >= POS_W'(count_q));
		sts.digest_eq  = (wd_q == pd_q);
		sts.mul_last   = (step_q == LAST_S);
		sts.cmp_eq     = (pat_rd_q == txt_rd_q);
		// The index has already moved past the byte under check.
		sts.cmp_last   = (cmp_j_q == count_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign match_start = match_q;

endmodule

FILE: rtl/rolling_hash_pattern_matcher.sv
// Top level of the rolling hash pattern matcher: joins controller and datapath.
// Depends on rhpm_pkg, rhpm_ctrl and rhpm_dp.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------
//   input    | in_valid, in_stall | command, data_byte
//   output   | out_valid,out_stall| match_start
//
// One beat is worked at a time. Clear, unused commands, a byte for a full pattern
// and a text byte with no pattern end after decode; a pattern byte then runs the
// power product (not for the first byte) and its digest, a text byte its window
// digest, after the product for the leaving byte once the window is full. When the
// digests agree, the window is compared byte by byte and a match loads the result.
// All products share one bit-serial modular multiplier and one window read port.
// arst_n clears the counts, digests and pointers; the byte memories keep no reset.
// A result waits in the output register while the next beat is taken; only a
// second match meeting a still stalled result holds the block.
module rolling_hash_pattern_matcher #(
	parameter int unsigned MAX_PATTERN  = rhpm_pkg::MAX_PATTERN_DEF,
	parameter int unsigned HASH_MODULUS = rhpm_pkg::HASH_MODULUS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rhpm_pkg::CMD_W-1:0]  command,
	input  logic [rhpm_pkg::BYTE_W-1:0] data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rhpm_pkg::POS_W-1:0]  match_start
);
	import rhpm_pkg::*;

	rhpm_ctl_t ctl;
	rhpm_sts_t sts;

	rhpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	rhpm_dp #(
		.MAX_PATTERN  (MAX_PATTERN),
		.HASH_MODULUS (HASH_MODULUS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.data_byte   (data_byte),
		.ctl         (ctl),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.match_start (match_start)
	);

	// A result must never overwrite one that is still stalled.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !(out_valid && out_stall))
		else $error("result loaded over a stalled result");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> out_valid)
		else $error("loaded result not presented");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second beat taken while the first is being worked");

	a_pattern_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pat_write |-> !sts.count_full)
		else $error("pattern byte written past the store");

endmodule
